@@ design/sibt_pkg.sv @@
// package for the cube/sphere intersection band test
// shared types, register codes and reset values; no dependencies
package sibt_pkg;

    // width of every square root taken in the pipeline
    localparam int unsigned ROOT_W = 34;
    localparam int unsigned RAD_W  = 2 * ROOT_W;
    localparam int unsigned EXC_W  = 35;

    // configuration register indexes
    localparam logic [7:0] REG_SPHERE_X      = 8'd0;
    localparam logic [7:0] REG_SPHERE_Y      = 8'd1;
    localparam logic [7:0] REG_SPHERE_Z      = 8'd2;
    localparam logic [7:0] REG_SPHERE_RADIUS = 8'd3;
    localparam logic [7:0] REG_BOX_X         = 8'd4;
    localparam logic [7:0] REG_BOX_Y         = 8'd5;
    localparam logic [7:0] REG_BOX_Z         = 8'd6;
    localparam logic [7:0] REG_BOX_HALF_SIZE = 8'd7;

    // reset values, Q16.16
    localparam logic [31:0] RST_SPHERE_X      = 32'd0;
    localparam logic [31:0] RST_SPHERE_Y      = 32'd0;
    localparam logic [31:0] RST_SPHERE_Z      = 32'd0;
    localparam logic [30:0] RST_SPHERE_RADIUS = 31'd131072;
    localparam logic [31:0] RST_BOX_X         = 32'd0;
    localparam logic [31:0] RST_BOX_Y         = 32'd196608;
    localparam logic [31:0] RST_BOX_Z         = 32'd0;
    localparam logic [30:0] RST_BOX_HALF_SIZE = 31'd131072;

    typedef struct packed {
        logic [31:0] sphere_x;
        logic [31:0] sphere_y;
        logic [31:0] sphere_z;
        logic [30:0] sphere_radius;
        logic [31:0] box_x;
        logic [31:0] box_y;
        logic [31:0] box_z;
        logic [30:0] box_half_size;
    } cfg_regs_t;

    // what the front end hands to the root pipelines
    typedef struct packed {
        logic                    valid;
        logic [RAD_W-1:0]        box_sum;
        logic [RAD_W-1:0]        sph_sum;
        logic [RAD_W-1:0]        marg_sum;
        logic signed [EXC_W-1:0] inner;
    } front_out_t;

    // sign extend the low cw bits of a word
    function automatic logic signed [31:0] sext_cw(logic [31:0] v, int unsigned cw);
        logic [31:0] t;
        t = v << (32 - cw);
        return $signed(t) >>> (32 - cw);
    endfunction

    // keep the low cw bits of a word
    function automatic logic [30:0] mask_cw(logic [30:0] v, int unsigned cw);
        logic [31:0] m;
        m = ~(32'hFFFF_FFFF << cw);
        return v & m[30:0];
    endfunction

endpackage

@@ design/sibt_ifs.sv @@
// channel interfaces for the band test: points in, results out, register writes
// depends on nothing
interface sibt_point_if;
    logic        valid;
    logic        ready;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [30:0] cell_size;
    modport source (output valid, point_x, point_y, point_z, cell_size, input ready);
    modport sink   (input valid, point_x, point_y, point_z, cell_size, output ready);
endinterface

interface sibt_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] box_distance;
    logic [31:0] sphere_distance;
    logic        near_surface;
    modport source (output valid, box_distance, sphere_distance, near_surface, input ready);
    modport sink   (input valid, box_distance, sphere_distance, near_surface, output ready);
endinterface

interface sibt_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/sdf_intersection_band_test_unit.sv @@
// top level of the cube/sphere intersection band test
// depends on sibt_pkg, sibt_ifs, sibt_front, sibt_sqrt_pipe
//
//  channel      dir  carries                                          taken when
//  point_in     in   point_x, point_y, point_z, cell_size             valid && ready
//  result_out   out  box_distance, sphere_distance, near_surface      valid && ready
//  cfg          in   index, data (register write)                     valid && ready
//
// one item per cycle while result_out is not stalled; 4 front stages + 34 root stages + 2
// output stages, the root stages set by the bit-per-stage square root pipelines.
// rst_n clears every valid bit and loads the register reset values.
// a stall on result_out freezes the whole pipeline and drops point_in.ready.
// cfg.ready is always high.
module sdf_intersection_band_test_unit #(
    parameter int unsigned COORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sibt_point_if.sink           point_in,
    sibt_result_if.source        result_out,
    sibt_cfg_if.sink             cfg
);
    localparam int unsigned CW = COORD_BITS < 32 ? COORD_BITS : 32;
    localparam int unsigned RW = sibt_pkg::ROOT_W;
    localparam int unsigned EW = sibt_pkg::EXC_W;

    sibt_pkg::cfg_regs_t  cfg_reg;
    sibt_pkg::front_out_t fo;

    logic adv;
    logic bv, sv, mv;
    logic [RW-1:0] len_b, len_s, marg;
    logic signed [EW-1:0] inner_d;
    logic [30:0] r_m;

    logic signed [36:0] bd_w, sd_w, sat_hi, sat_lo;
    logic signed [36:0] bd_sat, sd_sat;

    logic               v5_reg;
    logic signed [31:0] bd_reg, sd_reg;
    logic [RW-1:0]      marg_reg;

    logic signed [31:0] hi_d, lo_d;
    logic signed [RW+1:0] hi_x, nlo_x, marg_x;

    logic        out_valid_reg;
    logic [31:0] box_out_reg, sph_out_reg;
    logic        near_out_reg;

    // pipeline moves unless a result waits
    assign adv            = !out_valid_reg || result_out.ready;
    assign point_in.ready = adv;
    assign cfg.ready      = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sphere_x      <= sibt_pkg::RST_SPHERE_X;
            cfg_reg.sphere_y      <= sibt_pkg::RST_SPHERE_Y;
            cfg_reg.sphere_z      <= sibt_pkg::RST_SPHERE_Z;
            cfg_reg.sphere_radius <= sibt_pkg::RST_SPHERE_RADIUS;
            cfg_reg.box_x         <= sibt_pkg::RST_BOX_X;
            cfg_reg.box_y         <= sibt_pkg::RST_BOX_Y;
            cfg_reg.box_z         <= sibt_pkg::RST_BOX_Z;
            cfg_reg.box_half_size <= sibt_pkg::RST_BOX_HALF_SIZE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sibt_pkg::REG_SPHERE_X:      cfg_reg.sphere_x      <= cfg.data;
                sibt_pkg::REG_SPHERE_Y:      cfg_reg.sphere_y      <= cfg.data;
                sibt_pkg::REG_SPHERE_Z:      cfg_reg.sphere_z      <= cfg.data;
                sibt_pkg::REG_SPHERE_RADIUS: cfg_reg.sphere_radius <= cfg.data[30:0];
                sibt_pkg::REG_BOX_X:         cfg_reg.box_x         <= cfg.data;
                sibt_pkg::REG_BOX_Y:         cfg_reg.box_y         <= cfg.data;
                sibt_pkg::REG_BOX_Z:         cfg_reg.box_z         <= cfg.data;
                sibt_pkg::REG_BOX_HALF_SIZE: cfg_reg.box_half_size <= cfg.data[30:0];
                default: ;
            endcase
        end
    end

    sibt_front #(
        .CW (CW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (point_in.valid),
        .px       (point_in.point_x),
        .py       (point_in.point_y),
        .pz       (point_in.point_z),
        .w        (point_in.cell_size),
        .cfg      (cfg_reg),
        .fo       (fo)
    );

    // three root pipelines in lockstep
    sibt_sqrt_pipe #(
        .RW     (RW),
        .SIDE_W (EW)
    ) u_sqrt_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fo.valid),
        .rad       (fo.box_sum),
        .side_in   (fo.inner),
        .out_valid (bv),
        .root      (len_b),
        .side_out  (inner_d)
    );

    sibt_sqrt_pipe #(
        .RW     (RW),
        .SIDE_W (1)
    ) u_sqrt_sph (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fo.valid),
        .rad       (fo.sph_sum),
        .side_in   (fo.valid),
        .out_valid (sv),
        .root      (len_s),
        .side_out  ()
    );

    sibt_sqrt_pipe #(
        .RW     (RW),
        .SIDE_W (1)
    ) u_sqrt_marg (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fo.valid),
        .rad       (fo.marg_sum),
        .side_in   (fo.valid),
        .out_valid (mv),
        .root      (marg),
        .side_out  ()
    );

    // distances and saturation to the coordinate range
    always_comb
    begin
        r_m    = sibt_pkg::mask_cw(cfg_reg.sphere_radius, CW);
        sat_hi = 37'((64'd1 << (CW - 1)) - 64'd1);
        sat_lo = -sat_hi - 37'sd1;
        bd_w   = 37'(inner_d) + $signed({3'b0, len_b});
        sd_w   = $signed({3'b0, len_s}) - $signed({6'b0, r_m});
        bd_sat = bd_w > sat_hi ? sat_hi : (bd_w < sat_lo ? sat_lo : bd_w);
        sd_sat = sd_w > sat_hi ? sat_hi : (sd_w < sat_lo ? sat_lo : sd_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= bv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bd_reg   <= bd_sat[31:0];
            sd_reg   <= sd_sat[31:0];
            marg_reg <= marg;
        end
    end

    // band test against the margin
    always_comb
    begin
        hi_d   = bd_reg > sd_reg ? bd_reg : sd_reg;
        lo_d   = bd_reg < sd_reg ? bd_reg : sd_reg;
        hi_x   = (RW+2)'(hi_d);
        nlo_x  = -((RW+2)'(lo_d));
        marg_x = $signed({2'b0, marg_reg});
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            box_out_reg  <= bd_reg;
            sph_out_reg  <= sd_reg;
            near_out_reg <= (hi_x < marg_x) && (nlo_x < marg_x);
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.box_distance    = box_out_reg;
    assign result_out.sphere_distance = sph_out_reg;
    assign result_out.near_surface    = near_out_reg;

    // the three root pipelines carry the same items
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (bv == sv) && (bv == mv))
        else $error("root pipelines out of step");

    // a flagged item needs a nonzero margin
    a_flag_margin: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && adv && (hi_x < marg_x) && (nlo_x < marg_x)) |-> (marg_reg != '0))
        else $error("near surface with zero margin");

    // a waiting result blocks intake in the same cycle
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_out.ready) |-> !point_in.ready)
        else $error("intake open while result waits");

    // a held result keeps its last stage data frozen
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_out.ready) |=> $stable(v5_reg))
        else $error("pipeline moved during a stall");

endmodule

@@ design/sibt_front.sv @@
// front end: per-axis differences, squares and sums of squares, four stages
// depends on sibt_pkg
module sibt_front #(
    parameter int unsigned CW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [31:0]           px,
    input  logic [31:0]           py,
    input  logic [31:0]           pz,
    input  logic [30:0]           w,
    input  sibt_pkg::cfg_regs_t   cfg,
    output sibt_pkg::front_out_t  fo
);
    localparam int unsigned EW = sibt_pkg::EXC_W;
    localparam int unsigned RW = sibt_pkg::RAD_W;

    logic signed [31:0] p_s [3];
    logic signed [31:0] b_s [3];
    logic signed [31:0] s_s [3];
    logic [30:0] h_m;
    logic [30:0] w_m;

    logic signed [EW-1:0] exc [3];
    logic signed [EW-1:0] dmax;
    logic [32:0] bpos_next [3];
    logic [32:0] smag_next [3];

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [32:0] bpos_reg [3];
    logic [32:0] smag_reg [3];
    logic [30:0] w1_reg;
    logic signed [EW-1:0] inner1_reg, inner2_reg, inner3_reg, inner4_reg;

    logic [63:0] bp_reg [3];
    logic [63:0] sp_reg [3];
    logic [31:0] bl_reg [3];
    logic [31:0] sl_reg [3];
    logic        bh_reg [3];
    logic        sh_reg [3];
    logic [61:0] ww_reg;

    logic [65:0] bsq_reg [3];
    logic [65:0] ssq_reg [3];
    logic [61:0] wq_reg;
    logic [63:0] w3;

    logic [RW-1:0] bsum_reg, ssum_reg, msum_reg;

    // operands cut to the coordinate width
    always_comb
    begin
        p_s[0] = sibt_pkg::sext_cw(px, CW);
        p_s[1] = sibt_pkg::sext_cw(py, CW);
        p_s[2] = sibt_pkg::sext_cw(pz, CW);
        b_s[0] = sibt_pkg::sext_cw(cfg.box_x, CW);
        b_s[1] = sibt_pkg::sext_cw(cfg.box_y, CW);
        b_s[2] = sibt_pkg::sext_cw(cfg.box_z, CW);
        s_s[0] = sibt_pkg::sext_cw(cfg.sphere_x, CW);
        s_s[1] = sibt_pkg::sext_cw(cfg.sphere_y, CW);
        s_s[2] = sibt_pkg::sext_cw(cfg.sphere_z, CW);
        h_m    = sibt_pkg::mask_cw(cfg.box_half_size, CW);
        w_m    = sibt_pkg::mask_cw(w, CW);
    end

    // stage 1: excess over the cube per axis and sphere offsets
    always_comb
    begin
        logic signed [32:0] bd;
        logic signed [32:0] sd;
        logic [33:0] bad;
        for (int i = 0; i < 3; i++)
        begin
            bd  = 33'(p_s[i]) - 33'(b_s[i]);
            sd  = 33'(p_s[i]) - 33'(s_s[i]);
            bad = bd < 0 ? 34'(-35'(bd)) : 34'(bd);
            exc[i] = $signed({1'b0, bad}) - $signed({4'b0, h_m});
            bpos_next[i] = exc[i] > 0 ? exc[i][32:0] : 33'd0;
            smag_next[i] = sd < 0 ? 33'(-34'(sd)) : 33'(sd);
        end
        dmax = exc[0] > exc[1] ? exc[0] : exc[1];
        if (exc[2] > dmax)
        begin
            dmax = exc[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1 registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bpos_reg[i] <= bpos_next[i];
                smag_reg[i] <= smag_next[i];
            end
            w1_reg     <= w_m;
            inner1_reg <= dmax < 0 ? dmax : '0;
        end
    end

    // stage 2: 32x32 squares of the low words
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bp_reg[i] <= 64'(bpos_reg[i][31:0]) * 64'(bpos_reg[i][31:0]);
                sp_reg[i] <= 64'(smag_reg[i][31:0]) * 64'(smag_reg[i][31:0]);
                bl_reg[i] <= bpos_reg[i][31:0];
                sl_reg[i] <= smag_reg[i][31:0];
                bh_reg[i] <= bpos_reg[i][32];
                sh_reg[i] <= smag_reg[i][32];
            end
            ww_reg     <= 62'(w1_reg) * 62'(w1_reg);
            inner2_reg <= inner1_reg;
        end
    end

    // stage 3: fold in the top bit, three quarters of w squared
    assign w3 = 64'(ww_reg) + {1'b0, ww_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bsq_reg[i] <= 66'(bp_reg[i])
                    + (bh_reg[i] ? ({1'b0, bl_reg[i], 33'd0} + (66'd1 << 64)) : 66'd0);
                ssq_reg[i] <= 66'(sp_reg[i])
                    + (sh_reg[i] ? ({1'b0, sl_reg[i], 33'd0} + (66'd1 << 64)) : 66'd0);
            end
            wq_reg     <= w3[63:2];
            inner3_reg <= inner2_reg;
        end
    end

    // stage 4: sums of squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bsum_reg   <= RW'(bsq_reg[0]) + RW'(bsq_reg[1]) + RW'(bsq_reg[2]);
            ssum_reg   <= RW'(ssq_reg[0]) + RW'(ssq_reg[1]) + RW'(ssq_reg[2]);
            msum_reg   <= RW'(wq_reg);
            inner4_reg <= inner3_reg;
        end
    end

    assign fo.valid    = v4_reg;
    assign fo.box_sum  = bsum_reg;
    assign fo.sph_sum  = ssum_reg;
    assign fo.marg_sum = msum_reg;
    assign fo.inner    = inner4_reg;

endmodule

@@ design/sibt_sqrt_pipe.sv @@
// pipelined floor square root, one result bit per stage, with side data alongside
// depends on nothing
module sibt_sqrt_pipe #(
    parameter int unsigned RW     = 34,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [RW-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);
    logic              v_reg    [RW+1];
    logic [2*RW-1:0]   rad_reg  [RW+1];
    logic [RW+1:0]     rem_reg  [RW+1];
    logic [RW-1:0]     root_reg [RW+1];
    logic [SIDE_W-1:0] side_reg [RW+1];

    // stage zero is the input itself
    always_comb
    begin
        v_reg[0]    = in_valid;
        rad_reg[0]  = rad;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        side_reg[0] = side_in;
    end

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic [RW+1:0] r2;
        logic [RW+1:0] trial;

        // bring down two radicand bits and try the next root bit
        always_comb
        begin
            r2    = {rem_reg[s][RW-1:0], rad_reg[s][2*RW-1 -: 2]};
            trial = {root_reg[s], 2'b01};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s+1]  <= rad_reg[s] << 2;
                side_reg[s+1] <= side_reg[s];
                if (r2 >= trial)
                begin
                    rem_reg[s+1]  <= r2 - trial;
                    root_reg[s+1] <= {root_reg[s][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1]  <= r2;
                    root_reg[s+1] <= {root_reg[s][RW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign root      = root_reg[RW];
    assign side_out  = side_reg[RW];

endmodule
